// ===== rtl/acc_step_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Accumulator CPU step package
// Shared widths, status codes, instruction field codes and ALU/jump functions.
// ----------------------------------------------------------------------------
package acc_step_pkg;

  localparam int unsigned WORD_BITS       = 16;
  localparam int unsigned DATA_ADDR_BITS  = 15;
  localparam int unsigned PROG_WORDS      = 32768;
  localparam int unsigned OUT_FIELD_BITS  = 66;
  localparam int unsigned OUT_TDATA_BITS  = 72;

  localparam logic [1:0] STATUS_RUN     = 2'd0;
  localparam logic [1:0] STATUS_END     = 2'd1;
  localparam logic [1:0] STATUS_ILLEGAL = 2'd2;

  localparam logic [5:0] COMP_ZERO      = 6'h2A;
  localparam logic [5:0] COMP_ONE       = 6'h3F;
  localparam logic [5:0] COMP_MINUS_ONE = 6'h3A;
  localparam logic [5:0] COMP_D         = 6'h0C;
  localparam logic [5:0] COMP_Y         = 6'h30;
  localparam logic [5:0] COMP_NOT_D     = 6'h0D;
  localparam logic [5:0] COMP_NOT_Y     = 6'h31;
  localparam logic [5:0] COMP_NEG_D     = 6'h0F;
  localparam logic [5:0] COMP_NEG_Y     = 6'h33;
  localparam logic [5:0] COMP_D_INC     = 6'h1F;
  localparam logic [5:0] COMP_Y_INC     = 6'h37;
  localparam logic [5:0] COMP_D_DEC     = 6'h0E;
  localparam logic [5:0] COMP_Y_DEC     = 6'h32;
  localparam logic [5:0] COMP_D_ADD_Y   = 6'h02;
  localparam logic [5:0] COMP_D_SUB_Y   = 6'h13;
  localparam logic [5:0] COMP_Y_SUB_D   = 6'h07;
  localparam logic [5:0] COMP_D_AND_Y   = 6'h00;
  localparam logic [5:0] COMP_D_OR_Y    = 6'h15;

  localparam logic [2:0] JMP_NONE = 3'd0;
  localparam logic [2:0] JMP_GT   = 3'd1;
  localparam logic [2:0] JMP_EQ   = 3'd2;
  localparam logic [2:0] JMP_GE   = 3'd3;
  localparam logic [2:0] JMP_LT   = 3'd4;
  localparam logic [2:0] JMP_NE   = 3'd5;
  localparam logic [2:0] JMP_LE   = 3'd6;
  localparam logic [2:0] JMP_ALL  = 3'd7;

  typedef struct packed {
    logic        ok;
    logic [15:0] value;
  } alu_res_t;

  function automatic alu_res_t alu_eval(input logic [5:0] comp, input logic [15:0] d,
                                        input logic [15:0] y);
    alu_res_t r;
    r.ok = 1'b1;
    r.value = 16'h0000;
    unique case (comp)
      COMP_ZERO:      r.value = 16'h0000;
      COMP_ONE:       r.value = 16'h0001;
      COMP_MINUS_ONE: r.value = 16'hFFFF;
      COMP_D:         r.value = d;
      COMP_Y:         r.value = y;
      COMP_NOT_D:     r.value = ~d;
      COMP_NOT_Y:     r.value = ~y;
      COMP_NEG_D:     r.value = 16'h0000 - d;
      COMP_NEG_Y:     r.value = 16'h0000 - y;
      COMP_D_INC:     r.value = d + 16'h0001;
      COMP_Y_INC:     r.value = y + 16'h0001;
      COMP_D_DEC:     r.value = d - 16'h0001;
      COMP_Y_DEC:     r.value = y - 16'h0001;
      COMP_D_ADD_Y:   r.value = d + y;
      COMP_D_SUB_Y:   r.value = d - y;
      COMP_Y_SUB_D:   r.value = y - d;
      COMP_D_AND_Y:   r.value = d & y;
      COMP_D_OR_Y:    r.value = d | y;
      default:        r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic jump_taken(input logic [2:0] j, input logic [15:0] v);
    logic neg;
    logic zero;
    logic pos;
    logic t;
    neg  = v[15];
    zero = (v == 16'h0000);
    pos  = !neg && !zero;
    unique case (j)
      JMP_NONE: t = 1'b0;
      JMP_GT:   t = pos;
      JMP_EQ:   t = zero;
      JMP_GE:   t = !neg;
      JMP_LT:   t = neg;
      JMP_NE:   t = !zero;
      JMP_LE:   t = !pos;
      JMP_ALL:  t = 1'b1;
      default:  t = 1'b0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/accumulator_cpu_instruction_step_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Accumulator CPU instruction step unit
// Executes one fetched instruction word per input transaction.
// ----------------------------------------------------------------------------
// The s_axis channel carries the instruction word fetched at the last reported
// next_pc. Every accepted instruction yields exactly one m_axis transaction with
// the run status, next pc, A, D and ALU result in the cycle after acceptance.
// The program length register is written through the cfg channel, which is
// always ready.
// The data memory is read continuously at the current A register, so the
// operand is ready when an instruction arrives; a write to the address being
// read is forwarded. One instruction is accepted per cycle while the output
// register is empty or being drained; a stalled receiver holds the result and
// stops new instructions until it takes the transaction.
// After reset the data memory is cleared one word per cycle; no instruction
// is accepted during that pass.
// ----------------------------------------------------------------------------
module accumulator_cpu_instruction_step_unit
  import acc_step_pkg::*;
#(
  parameter int unsigned DataAddrBits = DATA_ADDR_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [WORD_BITS-1:0]      cfg_data_i,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: instr[15:0].
  input  wire logic [WORD_BITS-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // Fields from bit 0: run_status[1:0], next_pc[17:2], a_value[33:18],
  // d_value[49:34], alu_value[65:50], zero padding[71:66].
  output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata
);

  localparam int unsigned DataWords = 2 ** DataAddrBits;
  localparam logic [16:0] ProgLimit = 17'(PROG_WORDS);

  logic [15:0]             prog_len_q;
  logic [15:0]             a_q, a_d;
  logic [15:0]             d_q, d_d;
  logic [15:0]             pc_q, pc_d;
  logic [1:0]              halt_q, halt_d;
  logic                    clr_busy_q;
  logic [DataAddrBits-1:0] clr_addr_q;
  logic                    fwd_q;
  logic [15:0]             fwd_data_q;
  logic                    out_valid_q;
  logic [OUT_FIELD_BITS-1:0] out_data_q;

  logic                    accept;
  logic [15:0]             ins;
  logic [15:0]             ram_rdata;
  logic [15:0]             y_mem;
  logic [15:0]             y;
  logic [15:0]             alu;
  logic [15:0]             pc_inc;
  alu_res_t                res;
  logic                    exec_we;
  logic                    ram_we;
  logic [DataAddrBits-1:0] ram_waddr;
  logic [15:0]             ram_wdata;
  logic [DataAddrBits-1:0] ram_raddr;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !clr_busy_q && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ins           = s_axis_tdata;

  assign y_mem  = fwd_q ? fwd_data_q : ram_rdata;
  assign y      = ins[12] ? y_mem : a_q;
  assign res    = alu_eval(ins[11:6], d_q, y);
  assign pc_inc = pc_q + 16'd1;

  always_comb begin
    a_d     = a_q;
    d_d     = d_q;
    pc_d    = pc_q;
    halt_d  = halt_q;
    alu     = 16'h0000;
    exec_we = 1'b0;
    if (accept && (halt_q == STATUS_RUN)) begin
      if ((pc_q >= prog_len_q) || ({1'b0, pc_q} >= ProgLimit)) begin
        halt_d = STATUS_END;
      end else if (!ins[15]) begin
        a_d  = ins;
        pc_d = pc_inc;
      end else if (!res.ok) begin
        halt_d = STATUS_ILLEGAL;
      end else begin
        alu     = res.value;
        exec_we = ins[3];
        if (ins[5]) begin
          a_d = res.value;
        end
        if (ins[4]) begin
          d_d = res.value;
        end
        pc_d = jump_taken(ins[2:0], res.value) ? a_q : pc_inc;
      end
    end
  end

  assign ram_we    = clr_busy_q || exec_we;
  assign ram_waddr = clr_busy_q ? clr_addr_q : a_q[DataAddrBits-1:0];
  assign ram_wdata = clr_busy_q ? 16'h0000 : alu;
  assign ram_raddr = a_d[DataAddrBits-1:0];

  acc_step_ram #(
    .Width (WORD_BITS),
    .Depth (DataWords)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q  <= 16'd0;
      a_q         <= 16'd0;
      d_q         <= 16'd0;
      pc_q        <= 16'd0;
      halt_q      <= STATUS_RUN;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        prog_len_q <= cfg_data_i;
      end
      a_q    <= a_d;
      d_q    <= d_d;
      pc_q   <= pc_d;
      halt_q <= halt_d;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + {{(DataAddrBits - 1){1'b0}}, 1'b1};
        if (clr_addr_q == {DataAddrBits{1'b1}}) begin
          clr_busy_q <= 1'b0;
        end
      end
      fwd_q <= ram_we && (ram_waddr == ram_raddr);
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= ram_wdata;
    if (accept) begin
      out_data_q <= {alu, d_d, a_d, pc_d, halt_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_BITS - OUT_FIELD_BITS){1'b0}}, out_data_q};

endmodule
`default_nettype wire

// ===== rtl/acc_step_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module acc_step_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulator CPU instruction step unit testbench
// Feeds instruction words through the stream input, predicts the run status,
// next pc, A, D and ALU result of every step from a private model of the CPU
// state and data memory, and checks each output transaction against it.
// ----------------------------------------------------------------------------
module tb;
  import acc_step_pkg::*;

  localparam logic [2:0] DEST_NONE = 3'b000;
  localparam logic [2:0] DEST_M    = 3'b001;
  localparam logic [2:0] DEST_D    = 3'b010;
  localparam logic [2:0] DEST_DM   = 3'b011;
  localparam logic [2:0] DEST_AM   = 3'b101;
  localparam int         HOLD_CYCLES = 200;

  typedef struct packed {
    logic [15:0] alu_value;
    logic [15:0] d_value;
    logic [15:0] a_value;
    logic [15:0] next_pc;
    logic [1:0]  run_status;
  } step_result_t;

  class cpu_step_scoreboard;
    bit [15:0]          prog_len;
    bit [15:0]          reg_a;
    bit [15:0]          reg_d;
    bit [15:0]          cur_pc;
    bit [1:0]           halt_code;
    bit [WORD_BITS-1:0] ram [0:(1 << DATA_ADDR_BITS) - 1];
    step_result_t       expected_steps [$];
    int                 mismatches;

    function new();
      prog_len   = '0;
      mismatches = 0;
    endfunction

    function bit branch_taken(logic [2:0] cond, logic [15:0] v);
      bit neg;
      bit zero;
      bit pos;
      neg  = v[15];
      zero = (v == 16'h0000);
      pos  = !neg && !zero;
      case (cond)
        JMP_GT:  return pos;
        JMP_EQ:  return zero;
        JMP_GE:  return !neg;
        JMP_LT:  return neg;
        JMP_NE:  return !zero;
        JMP_LE:  return !pos;
        JMP_ALL: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function step_result_t exec_instr(logic [15:0] ins, bit commit);
      step_result_t              r;
      logic [15:0]               y;
      logic [15:0]               alu;
      logic [DATA_ADDR_BITS-1:0] addr;
      bit                        ok;
      r.run_status = halt_code;
      r.next_pc    = cur_pc;
      r.a_value    = reg_a;
      r.d_value    = reg_d;
      r.alu_value  = '0;
      addr = reg_a[DATA_ADDR_BITS-1:0];
      ok   = 1'b1;
      alu  = '0;
      if (halt_code != STATUS_RUN) return r;
      if (cur_pc >= prog_len || cur_pc >= PROG_WORDS) begin
        r.run_status = STATUS_END;
      end else if (!ins[15]) begin
        r.a_value = ins;
        r.next_pc = cur_pc + 16'd1;
      end else begin
        y = ins[12] ? ram[addr] : reg_a;
        case (ins[11:6])
          COMP_ZERO:      alu = 16'h0000;
          COMP_ONE:       alu = 16'h0001;
          COMP_MINUS_ONE: alu = 16'hFFFF;
          COMP_D:         alu = reg_d;
          COMP_Y:         alu = y;
          COMP_NOT_D:     alu = ~reg_d;
          COMP_NOT_Y:     alu = ~y;
          COMP_NEG_D:     alu = -reg_d;
          COMP_NEG_Y:     alu = -y;
          COMP_D_INC:     alu = reg_d + 16'd1;
          COMP_Y_INC:     alu = y + 16'd1;
          COMP_D_DEC:     alu = reg_d - 16'd1;
          COMP_Y_DEC:     alu = y - 16'd1;
          COMP_D_ADD_Y:   alu = reg_d + y;
          COMP_D_SUB_Y:   alu = reg_d - y;
          COMP_Y_SUB_D:   alu = y - reg_d;
          COMP_D_AND_Y:   alu = reg_d & y;
          COMP_D_OR_Y:    alu = reg_d | y;
          default:        ok = 1'b0;
        endcase
        if (!ok) begin
          r.run_status = STATUS_ILLEGAL;
        end else begin
          r.alu_value = alu;
          if (ins[5]) r.a_value = alu;
          if (ins[4]) r.d_value = alu;
          if (ins[3] && commit) ram[addr] = alu;
          r.next_pc = branch_taken(ins[2:0], alu) ? reg_a : cur_pc + 16'd1;
        end
      end
      if (commit) begin
        halt_code = r.run_status;
        cur_pc    = r.next_pc;
        reg_a     = r.a_value;
        reg_d     = r.d_value;
      end
      return r;
    endfunction

    function void note_instr(logic [15:0] ins);
      expected_steps.push_back(exec_instr(ins, 1'b1));
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) flag($sformatf("%s expected %h got %h", name, want, got));
    endfunction

    function void check_result(logic [OUT_TDATA_BITS-1:0] tdata);
      step_result_t got;
      step_result_t want;
      got = tdata[OUT_FIELD_BITS-1:0];
      if (expected_steps.size() == 0) begin
        flag($sformatf("result %h with no instruction outstanding", tdata));
        return;
      end
      want = expected_steps.pop_front();
      compare_field("run_status", 16'(want.run_status), 16'(got.run_status));
      compare_field("next_pc", want.next_pc, got.next_pc);
      compare_field("a_value", want.a_value, got.a_value);
      compare_field("d_value", want.d_value, got.d_value);
      compare_field("alu_value", want.alu_value, got.alu_value);
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [WORD_BITS-1:0]      cfg_data_i;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [WORD_BITS-1:0]      s_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

  cpu_step_scoreboard sb;
  bit                 hold_req = 1'b0;
  bit                 quiet = 1'b0;

  accumulator_cpu_instruction_step_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [5:0] comp_code(int k);
    case (k)
      0:       return COMP_ZERO;
      1:       return COMP_ONE;
      2:       return COMP_MINUS_ONE;
      3:       return COMP_D;
      4:       return COMP_Y;
      5:       return COMP_NOT_D;
      6:       return COMP_NOT_Y;
      7:       return COMP_NEG_D;
      8:       return COMP_NEG_Y;
      9:       return COMP_D_INC;
      10:      return COMP_Y_INC;
      11:      return COMP_D_DEC;
      12:      return COMP_Y_DEC;
      13:      return COMP_D_ADD_Y;
      14:      return COMP_D_SUB_Y;
      15:      return COMP_Y_SUB_D;
      16:      return COMP_D_AND_Y;
      default: return COMP_D_OR_Y;
    endcase
  endfunction

  function automatic logic [15:0] c_instr(logic [1:0] hi, logic use_mem, logic [5:0] comp,
                                          logic [2:0] dest, logic [2:0] cond);
    return {1'b1, hi, use_mem, comp, dest, cond};
  endfunction

  function automatic logic [15:0] random_instr();
    if ($urandom_range(0, 99) < 35) begin
      if ($urandom_range(0, 1) != 0) return {1'b0, 15'($urandom_range(0, 63))};
      return {1'b0, 15'($urandom)};
    end
    return c_instr(2'($urandom), 1'($urandom), comp_code($urandom_range(0, 17)),
                   3'($urandom), 3'($urandom));
  endfunction

  // A step is kept only if the program can still go on afterwards: the next pc
  // lies inside the program and either pc + 1 or a jump to A stays inside too.
  function automatic bit keeps_running(logic [15:0] ins);
    step_result_t r;
    logic [16:0]  after;
    r = sb.exec_instr(ins, 1'b0);
    after = {1'b0, r.next_pc} + 17'd1;
    return r.run_status == STATUS_RUN && r.next_pc < sb.prog_len &&
           (after < {1'b0, sb.prog_len} || r.a_value < sb.prog_len);
  endfunction

  function automatic logic [15:0] pick_instr();
    logic [15:0] cand;
    for (int t = 0; t < 24; t++) begin
      cand = random_instr();
      if (keeps_running(cand)) return cand;
    end
    if (sb.reg_a < sb.prog_len)
      return c_instr(2'($urandom), 1'($urandom), comp_code($urandom_range(0, 17)),
                     3'($urandom) & DEST_DM, JMP_ALL);
    return {1'b0, 15'($urandom_range(0, int'(sb.prog_len) - 1))};
  endfunction

  task automatic send_instr(input logic [15:0] ins);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ins;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_instr(ins);
  endtask

  task automatic idle_gap();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_steps.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [15:0] len);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.prog_len = len;
  endtask

  task automatic run_phase(input logic [15:0] len, input int count, input int hold_at,
                           input int pause_at, input int quiet_from);
    wait_drained();
    repeat (4) @(posedge clk_i);
    write_length(len);
    for (int i = 0; i < count; i++) begin
      if (i == quiet_from) quiet = 1'b1;
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) wait_drained();
      if (!quiet && !hold_req && $urandom_range(0, 3) == 0) idle_gap();
      send_instr(pick_instr());
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin : receiver
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [15:0]  cand;
    step_result_t probe;
    int           waited;
    sb = new();
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_length(16'h8000);

    send_instr(16'h0000);
    send_instr(16'hFFFF);
    send_instr(16'h7FFF);
    send_instr(c_instr(2'b11, 1'b0, COMP_MINUS_ONE, DEST_D, JMP_NONE));
    send_instr(c_instr(2'b11, 1'b0, COMP_D, DEST_M, JMP_NONE));
    send_instr(c_instr(2'b11, 1'b1, COMP_Y_INC, DEST_AM, JMP_NONE));
    send_instr(16'h1234);
    for (int i = 0; i < 18; i++)
      send_instr(c_instr(2'(i), 1'(i), comp_code(i), DEST_DM, 3'(i)));
    send_instr(16'h0000);
    send_instr(c_instr(2'b11, 1'b0, COMP_ZERO, DEST_NONE, JMP_ALL));

    run_phase(16'd1, 30, -1, -1, -1);
    run_phase(16'd40, 150, -1, -1, -1);
    run_phase(16'd300, 250, 50, -1, -1);
    run_phase(16'($urandom_range(1000, 20000)), 300, -1, 100, -1);
    run_phase(16'h8000, 420, -1, -1, 270);

    if ($urandom_range(0, 1) != 0) begin
      wait_drained();
      repeat (4) @(posedge clk_i);
      write_length(16'd0);
    end else begin
      do begin
        cand = c_instr(2'($urandom), 1'($urandom), 6'($urandom), 3'($urandom), 3'($urandom));
        probe = sb.exec_instr(cand, 1'b0);
      end while (probe.run_status != STATUS_ILLEGAL);
      send_instr(cand);
    end
    repeat (6) send_instr(16'($urandom));

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (sb.expected_steps.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    while (sb.expected_steps.size() != 0) begin
      probe = sb.expected_steps.pop_front();
      sb.flag($sformatf("no result for step expecting next_pc %h", probe.next_pc));
    end
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
